FILE: src/source_byte_tokenizer_defines.svh
// assertion macros for the source byte tokenizer checker
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH

// a property that must hold at every rising clock edge while out of reset
`define SBT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// a property that is checked in reset too
`define SBT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// types, constants and keyword table for the source byte tokenizer
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int CountBits    = 20;
    localparam int KeywordBytes = 12;
    localparam int KwMax        = 16;
    localparam int NumKw        = 24;

    // scanner modes
    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_IDENT, M_NUM, M_NUM_DOT, M_FRAC, M_STR, M_LINE_C,
        M_BLOCK, M_BLOCK_STAR, M_DONE
    } t_mode;

    // token kinds
    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_STRING = 6'd3;
    localparam logic [5:0] K_SLASH  = 6'd16;

    // error codes
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_BYTE  = 2'd1;
    localparam logic [1:0] E_STR   = 2'd2;
    localparam logic [1:0] E_BLOCK = 2'd3;

    // one result word, counters at the full port width
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_code;
        logic [7:0]  bad_byte;
        logic [19:0] line_number;
        logic [19:0] column_number;
        logic [19:0] text_start;
        logic [19:0] text_length;
        logic        run_last;
        logic        source_done;
    } t_result;

    // keyword text, byte 0 in the low bits, zero padded
    function automatic logic [8*KwMax-1:0] kw_text(input int i);
        logic [8*KwMax-1:0] t;
        t = '0;
        case (i)
            0:  t = {8'h73,8'h69,8'h61,8'h67,8'hAB,8'hC4,8'h6E,8'h69,8'h61,8'h4D};
            1:  t = {8'h61,8'h6A,8'h69,8'h63,8'h6B,8'h6E,8'h75,8'h46};
            2:  t = {8'h61,8'h4A};
            3:  t = {8'h72,8'h93,8'hC4,8'h6D,8'h61,8'h4B};
            4:  t = {8'h74,8'h7A,8'h65,8'h69,8'h72,8'h67,8'h74,8'h41};
            5:  t = {8'h69,8'h64,8'h81,8'hC4,8'h74,8'h69,8'h43};
            6:  t = {8'h73,8'h69,8'h6C,8'h74,8'h69,8'h61,8'h6B,8'h73};
            7:  t = {8'h73,8'h74,8'h73,8'h6B,8'h65,8'h74};
            8:  t = {8'h73,8'h6B,8'h73,8'h69,8'hA3,8'hC4,8'h6F,8'h6C};
            9:  t = {8'h73,8'h76,8'hAB,8'hC4,8'h73,8'h61,8'h6D};
            10: t = {8'h73,8'h73,8'h65,8'h69,8'h74,8'h61,8'h70};
            11: t = {8'h73,8'h6D,8'h61,8'h6C,8'h70,8'h61};
            12: t = {8'h72,8'h69};
            13: t = {8'h73,8'h64,8'h81,8'hC4,8'h6E,8'h65,8'h69,8'h76};
            14: t = {8'h73,8'h6B,8'h81,8'hC4,8'h7A,8'h61,8'h6D};
            15: t = {8'h73,8'h6B,8'h81,8'hC4,8'h6C,8'h65,8'h69,8'h6C};
            16: t = {8'h72,8'h61,8'h70};
            17: t = {8'h72,8'h61};
            18: t = {8'h74,8'hAB,8'hC4,8'h74,8'h69,8'h61,8'h6B,8'h73,8'h65,8'h69,8'h70};
            19: t = {8'h6E,8'h75};
            20: t = {8'h69,8'h61,8'h76};
            21: t = {8'h76,8'h61,8'h6E};
            22: t = {8'h73,8'h6D,8'h75,8'h6B,8'h69,8'h6C,8'h74,8'h61};
            23: t = {8'h74,8'hAB,8'hC4,8'h64,8'h61,8'h76,8'h7A,8'h49};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] kw_len(input int i);
        logic [4:0] l;
        case (i)
            0: l = 5'd10;  1: l = 5'd8;  2: l = 5'd2;  3: l = 5'd6;
            4: l = 5'd8;   5: l = 5'd7;  6: l = 5'd8;  7: l = 5'd6;
            8: l = 5'd8;   9: l = 5'd7;  10: l = 5'd7; 11: l = 5'd6;
            12: l = 5'd2;  13: l = 5'd8; 14: l = 5'd7; 15: l = 5'd8;
            16: l = 5'd3;  17: l = 5'd2; 18: l = 5'd11; 19: l = 5'd2;
            20: l = 5'd3;  21: l = 5'd3; 22: l = 5'd8; 23: l = 5'd8;
            default: l = 5'd0;
        endcase
        return l;
    endfunction

    function automatic logic [5:0] kw_kind(input int i);
        logic [5:0] k;
        if (i < 10) k = 6'(17 + i);
        else if (i < 12) k = 6'd4;
        else k = 6'(15 + i);
        return k;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h28: k = 6'd5;  8'h29: k = 6'd6;  8'h7B: k = 6'd7;
            8'h5B: k = 6'd8;  8'h5D: k = 6'd9;  8'h7D: k = 6'd10;
            8'h2C: k = 6'd11; 8'h3B: k = 6'd12; 8'h2B: k = 6'd13;
            8'h2D: k = 6'd14; 8'h2A: k = 6'd15;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_id_start(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               b == 8'h5F || b == 8'h40 || b == 8'h23 || b[7];
    endfunction

endpackage

FILE: src/source_byte_tokenizer.sv
// the scanner forms result words combinationally from each byte; the queue registers them
// throughput: one byte per cycle while full is low; full rises while three or more words wait
// a byte may give two result words, drained one per pop
// reset: synchronous active-low i_rst_n returns scanner and queue to empty
// state with line 1, column 1, offset 0
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// streaming lexer top level: scanner front part and result queue
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
    parameter int COUNT_BITS    = sbt_pkg::CountBits,
    parameter int KEYWORD_BYTES = sbt_pkg::KeywordBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_byte_value,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [1:0]  o_error_code,
    output logic [7:0]  o_bad_byte,
    output logic [19:0] o_line_number,
    output logic [19:0] o_column_number,
    output logic [19:0] o_text_start,
    output logic [19:0] o_text_length,
    output logic        o_run_last,
    output logic        o_source_done
);
    import sbt_pkg::*;

    logic    v0, v1;
    t_result res0, res1, res;

    sbt_scan #(.COUNT_BITS(COUNT_BITS), .KEYWORD_BYTES(KEYWORD_BYTES)) u_scan (
        .i_clk, .i_rst_n, .i_valid(push && !full), .i_kind, .i_byte_value,
        .o_valid0(v0), .o_valid1(v1), .o_res0(res0), .o_res1(res1)
    );

    sbt_queue u_queue (
        .i_clk, .i_rst_n, .i_valid0(v0), .i_valid1(v1), .i_res0(res0), .i_res1(res1),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_res(res)
    );

    assign o_token_kind    = res.token_kind;
    assign o_error_code    = res.error_code;
    assign o_bad_byte      = res.bad_byte;
    assign o_line_number   = res.line_number;
    assign o_column_number = res.column_number;
    assign o_text_start    = res.text_start;
    assign o_text_length   = res.text_length;
    assign o_run_last      = res.run_last;
    assign o_source_done   = res.source_done;

endmodule

FILE: src/sbt_scan.sv
// ----------------------------------------------------------------------------
// sbt_scan
// front part: mode machine, counters, word buffer, keyword match; up to two
// result words per byte pushed into the queue
// ----------------------------------------------------------------------------
module sbt_scan #(
    parameter int COUNT_BITS    = sbt_pkg::CountBits,
    parameter int KEYWORD_BYTES = sbt_pkg::KeywordBytes
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_kind,
    input  logic [7:0]       i_byte_value,
    output logic             o_valid0,
    output logic             o_valid1,
    output sbt_pkg::t_result o_res0,
    output sbt_pkg::t_result o_res1
);
    import sbt_pkg::*;

    localparam logic [COUNT_BITS-1:0] CntMax = '1;
    localparam int LenBits = $clog2(KEYWORD_BYTES + 2);
    localparam int IdxBits = $clog2(KEYWORD_BYTES);
    localparam logic [LenBits-1:0] KwB = LenBits'(KEYWORD_BYTES);

    t_mode                 r_mode, n_mode;
    logic [COUNT_BITS-1:0] r_line, n_line, r_col, n_col, r_off, n_off;
    logic [COUNT_BITS-1:0] r_tstart, n_tstart, r_tcol, n_tcol;
    logic [LenBits-1:0]    r_wlen, n_wlen;
    logic [7:0]            r_wbuf [KEYWORD_BYTES];
    logic                  wr_en;
    logic [IdxBits-1:0]    wr_idx;
    logic [5:0]            word_kind;

    function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction

    function automatic logic [19:0] to20(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[19:0];
    endfunction

    // parallel keyword compare against the buffered word
    always_comb begin
        logic hit;
        logic [8*KwMax-1:0] txt;
        word_kind = K_IDENT;
        for (int i = NumKw - 1; i >= 0; i--) begin
            txt = kw_text(i);
            hit = (32'(kw_len(i)) == 32'(r_wlen)) && (r_wlen <= KwB);
            for (int k = 0; k < KEYWORD_BYTES; k++) begin
                if (k < 32'(kw_len(i)) && r_wbuf[k] != txt[8*k +: 8]) hit = 1'b0;
            end
            if (hit) word_kind = kw_kind(i);
        end
    end

    // next state and result words
    always_comb begin
        t_result r, pend;
        logic [7:0] b;
        logic again, tok_ok;
        logic [COUNT_BITS-1:0] slen;
        n_mode = r_mode; n_line = r_line; n_col = r_col; n_off = r_off;
        n_tstart = r_tstart; n_tcol = r_tcol; n_wlen = r_wlen;
        wr_en = 1'b0; wr_idx = '0;
        o_valid0 = 1'b0; o_valid1 = 1'b0;
        o_res0 = '0; o_res1 = '0;
        b = i_byte_value;
        again = 1'b0;
        r = '0;
        pend = '0;
        pend.line_number = to20(r_line);
        pend.column_number = to20(r_tcol);
        pend.text_start = to20(r_tstart);
        pend.text_length = to20((r_off > r_tstart) ? r_off - r_tstart : '0);
        r.line_number = to20(r_line);
        slen = (r_off > r_tstart) ? r_off - r_tstart : '0;
        slen = (slen > 0) ? slen - 1'b1 : '0;
        tok_ok = 1'b0;
        if (i_valid && !i_kind) begin
            // first pass: pending token ends, or the whole byte is handled
            case (r_mode)
                M_SLASH: begin
                    if (b == 8'h2F) begin n_mode = M_LINE_C; tok_ok = 1'b1; end
                    else if (b == 8'h2A) begin n_mode = M_BLOCK; tok_ok = 1'b1; end
                    else begin
                        o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_SLASH;
                        again = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_id_start(b) || is_digit(b)) begin
                        if (r_wlen < KwB) begin
                            wr_en = 1'b1; wr_idx = IdxBits'(r_wlen);
                        end
                        if (r_wlen <= KwB) n_wlen = r_wlen + 1'b1;
                        tok_ok = 1'b1;
                    end else begin
                        o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = word_kind;
                        again = 1'b1;
                    end
                end
                M_NUM, M_FRAC: begin
                    if (is_digit(b)) tok_ok = 1'b1;
                    else if (r_mode == M_NUM && b == 8'h2E) n_mode = M_NUM_DOT;
                    else begin
                        o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_NUMBER;
                        again = 1'b1;
                    end
                end
                M_NUM_DOT: begin
                    if (is_digit(b)) begin
                        // dot and digit both counted
                        n_off = inc_sat(inc_sat(r_off));
                        n_col = inc_sat(inc_sat(r_col));
                        n_mode = M_FRAC;
                    end else begin
                        o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_NUMBER;
                        o_valid1 = 1'b1;
                        o_res1.error_code = E_BYTE; o_res1.bad_byte = 8'h2E;
                        o_res1.line_number = to20(r_line);
                        o_res1.column_number = to20(r_col);
                        o_res1.source_done = 1'b1;
                        n_mode = M_DONE;
                    end
                end
                M_STR: begin
                    if (b == 8'h22) begin
                        o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_STRING;
                        o_res0.text_start = to20(inc_sat(r_tstart));
                        o_res0.text_length = to20(slen);
                        n_mode = M_IDLE;
                    end
                    tok_ok = 1'b1;
                end
                M_LINE_C: begin
                    if (b == 8'h0A) again = 1'b1;
                    else tok_ok = 1'b1;
                end
                M_BLOCK: begin
                    if (b == 8'h2A) n_mode = M_BLOCK_STAR;
                    tok_ok = 1'b1;
                end
                M_BLOCK_STAR: begin
                    if (b == 8'h2F) n_mode = M_IDLE;
                    else if (b != 8'h2A) n_mode = M_BLOCK;
                    tok_ok = 1'b1;
                end
                M_IDLE: again = 1'b1;
                default: ;
            endcase
            if (tok_ok) begin
                n_off = inc_sat(r_off);
                if (b == 8'h0A) begin n_line = inc_sat(r_line); n_col = COUNT_BITS'(1); end
                else n_col = inc_sat(r_col);
            end
            // idle pass on the byte
            if (again) begin
                n_mode = M_IDLE;
                n_tstart = r_off; n_tcol = r_col;
                r.column_number = to20(r_col);
                r.text_start = to20(r_off);
                n_off = inc_sat(r_off);
                if (b == 8'h0A) begin n_line = inc_sat(r_line); n_col = COUNT_BITS'(1); end
                else n_col = inc_sat(r_col);
                if (punct_kind(b) != 6'd0) begin
                    r.token_kind = punct_kind(b); r.text_length = 20'd1;
                end else if (b == 8'h2F) n_mode = M_SLASH;
                else if (b == 8'h22) n_mode = M_STR;
                else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) ;
                else if (is_digit(b)) n_mode = M_NUM;
                else if (is_id_start(b)) begin
                    wr_en = 1'b1; wr_idx = '0; n_wlen = LenBits'(1); n_mode = M_IDENT;
                end else begin
                    r.error_code = E_BYTE; r.bad_byte = b; r.text_start = '0;
                    r.source_done = 1'b1;
                    n_off = r_off; n_col = r_col; n_line = r_line;
                    n_mode = M_DONE;
                end
                if (punct_kind(b) != 6'd0 || r.error_code != E_NONE) begin
                    if (o_valid0) begin o_valid1 = 1'b1; o_res1 = r; end
                    else begin o_valid0 = 1'b1; o_res0 = r; end
                end
            end
        end else if (i_valid && i_kind) begin
            // end of source: flush, then eof or an error
            r.column_number = to20(r_col);
            r.text_start = to20(r_off);
            r.source_done = 1'b1;
            case (r_mode)
                M_SLASH: begin o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_SLASH; end
                M_IDENT: begin o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = word_kind; end
                M_NUM, M_FRAC, M_NUM_DOT: begin
                    o_valid0 = 1'b1; o_res0 = pend; o_res0.token_kind = K_NUMBER;
                end
                default: ;
            endcase
            if (r_mode == M_NUM_DOT) begin
                r.error_code = E_BYTE; r.bad_byte = 8'h2E; r.text_start = '0;
            end else if (r_mode == M_STR || r_mode == M_BLOCK || r_mode == M_BLOCK_STAR) begin
                r.error_code = (r_mode == M_STR) ? E_STR : E_BLOCK;
                r.column_number = to20(r_tcol); r.text_start = '0;
            end
            if (r_mode != M_DONE) begin
                if (o_valid0) begin o_valid1 = 1'b1; o_res1 = r; end
                else begin o_valid0 = 1'b1; o_res0 = r; end
            end
            n_mode = M_IDLE; n_line = COUNT_BITS'(1); n_col = COUNT_BITS'(1);
            n_off = '0; n_tstart = '0; n_tcol = COUNT_BITS'(1); n_wlen = '0;
            if (r_mode == M_NUM_DOT || r_mode == M_STR || r_mode == M_BLOCK ||
                r_mode == M_BLOCK_STAR) begin
                n_mode = M_DONE; n_line = r_line; n_col = r_col; n_off = r_off;
                n_tstart = r_tstart; n_tcol = r_tcol; n_wlen = r_wlen;
            end
        end
        // run_last on the final word of this item
        if (o_valid1) o_res1.run_last = 1'b1;
        else if (o_valid0) o_res0.run_last = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= COUNT_BITS'(1); r_col <= COUNT_BITS'(1); r_off <= '0;
            r_tstart <= '0; r_tcol <= COUNT_BITS'(1); r_wlen <= '0;
        end else begin
            r_mode <= n_mode;
            r_line <= n_line; r_col <= n_col; r_off <= n_off;
            r_tstart <= n_tstart; r_tcol <= n_tcol; r_wlen <= n_wlen;
        end
    end

    // word buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) r_wbuf[wr_idx] <= i_byte_value;
    end

endmodule

FILE: src/sbt_queue.sv
// ----------------------------------------------------------------------------
// sbt_queue
// back part: result queue taking up to two words a cycle, one out per pop
// ----------------------------------------------------------------------------
module sbt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid0,
    input  logic             i_valid1,
    input  sbt_pkg::t_result i_res0,
    input  sbt_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output sbt_pkg::t_result o_res
);
    import sbt_pkg::*;

    localparam int Depth = 4;
    t_result    r_mem [Depth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop_ok;

    // a new byte needs room for two words
    assign o_full  = r_cnt > 3'd2;
    assign o_empty = r_cnt == 3'd0;
    assign o_res   = r_mem[r_rp];
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt + 3'(i_valid0) + 3'(i_valid1) - 3'(pop_ok);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + 2'(i_valid0) + 2'(i_valid1);
            r_rp  <= r_rp + 2'(pop_ok);
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_valid0) r_mem[r_wp] <= i_res0;
        if (i_valid1) r_mem[r_wp + 2'd1] <= i_res1;
    end

endmodule

FILE: src/sbt_checker.sv
// ----------------------------------------------------------------------------
// sbt_checker
// port-level checks on the tokenizer result side
// ----------------------------------------------------------------------------
`include "source_byte_tokenizer_defines.svh"

module sbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_error_code,
    input logic        o_source_done,
    input logic [19:0] o_line_number,
    input logic [19:0] o_column_number
);
    import sbt_pkg::*;

    // an error word always finishes the source
    `SBT_ASSERT(a_err_done, i_clk, i_rst_n, (!empty && o_error_code != E_NONE) |-> o_source_done, "error word without source_done")
    // line and column are never zero
    `SBT_ASSERT(a_line_nz, i_clk, i_rst_n, !empty |-> (o_line_number != 20'd0 && o_column_number != 20'd0), "zero line or column")
    // no words without a push before
    `SBT_ASSERT(a_no_invent, i_clk, i_rst_n, ($past(empty) && !$past(push) && !$past(pop)) |-> empty, "word appeared without input")
    // queue empty out of reset
    `SBT_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> (empty && !full), "queue not empty after reset")
endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .o_error_code, .o_source_done,
    .o_line_number, .o_column_number
);
